FILE: design/assert_macros.svh
// Assertion macros shared by the sanitizer RTL.
// Checks compile away when SYNTHESIS is defined; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define USS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: property violated");
`define USS_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define USS_ASSERT(lbl, clk, rst_n, prop)
`define USS_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: design/uss_pkg.sv
// Package for the UTF-8 stream sanitizer: byte constants, job type,
// lead-byte decode. No dependencies.
package uss_pkg;

  localparam logic [7:0] AsciiLimit = 8'h80;
  localparam logic [7:0] Lead2Min   = 8'hC2;
  localparam logic [7:0] Lead3Min   = 8'hE0;
  localparam logic [7:0] Lead4Min   = 8'hF0;
  localparam logic [7:0] LeadLimit  = 8'hF5;
  localparam logic [7:0] LeadE0     = 8'hE0;
  localparam logic [7:0] LeadED     = 8'hED;
  localparam logic [7:0] LeadF0     = 8'hF0;
  localparam logic [7:0] LeadF4     = 8'hF4;
  localparam logic [7:0] ContLow    = 8'h80;
  localparam logic [7:0] ContHigh   = 8'hBF;
  localparam logic [7:0] LowAfterE0 = 8'hA0;
  localparam logic [7:0] HighAfterED = 8'h9F;
  localparam logic [7:0] LowAfterF0 = 8'h90;
  localparam logic [7:0] HighAfterF4 = 8'h8F;
  localparam logic [7:0] Repl0      = 8'hEF;
  localparam logic [7:0] Repl1      = 8'hBF;
  localparam logic [7:0] Repl2      = 8'hBD;

  localparam int MaxBytes  = 6;
  localparam int FifoDepth = 4;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int CntW      = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic [2:0]            len;
    logic [MaxBytes-1:0][7:0] bytes;
  } job_t;

  typedef struct packed {
    logic [1:0] held_count;
    logic [2:0] expected_length;
  } front_stat_t;

  typedef struct packed {
    logic [7:0] low;
    logic [7:0] high;
  } bounds_t;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    if (b < AsciiLimit)     len = 3'd1;
    else if (b < Lead2Min)  len = 3'd0;
    else if (b < Lead3Min)  len = 3'd2;
    else if (b < Lead4Min)  len = 3'd3;
    else if (b < LeadLimit) len = 3'd4;
    else                    len = 3'd0;
    return len;
  endfunction

  function automatic bounds_t lead_bounds(input logic [7:0] b);
    bounds_t bnd;
    bnd.low  = ContLow;
    bnd.high = ContHigh;
    if (b == LeadE0)      bnd.low  = LowAfterE0;
    else if (b == LeadED) bnd.high = HighAfterED;
    else if (b == LeadF0) bnd.low  = LowAfterF0;
    else if (b == LeadF4) bnd.high = HighAfterF4;
    return bnd;
  endfunction

endpackage

FILE: design/uss_front.sv
// Front end: accepts items, tracks the partial UTF-8 sequence and builds
// at most one output job per item. Depends on uss_pkg.
module uss_front import uss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [7:0]  byte_i,
  input  logic        job_ready_i,
  output logic        job_valid_o,
  output job_t        job_o,
  output front_stat_t stat_o
);

  logic [1:0]      held_cnt_q, held_cnt_d;
  logic [2:0]      exp_len_q, exp_len_d;
  logic [7:0]      low_q, low_d, high_q, high_d;
  logic [2:0][7:0] held_q, held_d;
  logic            accept;
  job_t            job;
  logic [2:0]      ll;
  logic [2:0]      base;
  logic            do_lead;
  bounds_t         bnd;

  assign in_ready_o  = job_ready_i;
  assign accept      = in_valid_i && job_ready_i;
  assign job_valid_o = accept && (job.len != 3'd0);
  assign job_o       = job;
  assign stat_o      = '{held_count: held_cnt_q, expected_length: exp_len_q};

  always_comb begin
    held_cnt_d = held_cnt_q;
    exp_len_d  = exp_len_q;
    low_d      = low_q;
    high_d     = high_q;
    held_d     = held_q;
    job        = '0;
    base       = 3'd0;
    do_lead    = 1'b0;
    ll         = lead_len(byte_i);
    bnd        = lead_bounds(byte_i);
    if (mode_i) begin
      held_cnt_d = 2'd0;
      exp_len_d  = 3'd0;
    end else if (held_cnt_q == 2'd0) begin
      do_lead = 1'b1;
    end else if (byte_i < low_q || byte_i > high_q) begin
      held_cnt_d    = 2'd0;
      job.bytes[0]  = Repl0;
      job.bytes[1]  = Repl1;
      job.bytes[2]  = Repl2;
      job.len       = 3'd3;
      base          = 3'd3;
      do_lead       = 1'b1;
    end else begin
      low_d  = ContLow;
      high_d = ContHigh;
      if ((3'(held_cnt_q) + 3'd1 >= exp_len_q) || (held_cnt_q == 2'd3)) begin
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < held_cnt_q) job.bytes[i] = held_q[i];
        end
        job.bytes[3'(held_cnt_q)] = byte_i;
        job.len    = 3'(held_cnt_q) + 3'd1;
        held_cnt_d = 2'd0;
      end else begin
        held_d[held_cnt_q] = byte_i;
        held_cnt_d         = held_cnt_q + 2'd1;
      end
    end
    if (do_lead) begin
      case (ll)
        3'd0: begin
          job.bytes[base]        = Repl0;
          job.bytes[base + 3'd1] = Repl1;
          job.bytes[base + 3'd2] = Repl2;
          job.len                = base + 3'd3;
        end
        3'd1: begin
          job.bytes[base] = byte_i;
          job.len         = base + 3'd1;
        end
        default: begin
          held_d[0]  = byte_i;
          held_cnt_d = 2'd1;
          exp_len_d  = ll;
          low_d      = bnd.low;
          high_d     = bnd.high;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt_q <= 2'd0;
      exp_len_q  <= 3'd0;
      low_q      <= ContLow;
      high_q     <= ContHigh;
    end else if (accept) begin
      held_cnt_q <= held_cnt_d;
      exp_len_q  <= exp_len_d;
      low_q      <= low_d;
      high_q     <= high_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q <= held_d;
    end
  end

endmodule

FILE: design/uss_job_fifo.sv
// Job queue between front end and serializer.
// Depends on uss_pkg (job_t, FifoDepth).
module uss_job_fifo import uss_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  output logic full_o,
  input  logic pop_i,
  output logic head_valid_o,
  output job_t head_o
);

  job_t            mem_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o       = (cnt_q == CntW'(FifoDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + PtrW'(1);
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

FILE: design/uss_back.sv
// Serializer: walks the head job one byte per cycle into the output register while output is not stalled.
// Depends on uss_pkg (job_t).
module uss_back import uss_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  job_t       head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  logic [2:0] idx_q;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic       load;
  logic       is_last;

  assign load        = head_valid_i && (!out_valid_q || out_ready_i);
  assign is_last     = (idx_q == head_i.len - 3'd1);
  assign pop_o       = load && is_last;
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= is_last ? 3'd0 : idx_q + 3'd1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= head_i.bytes[idx_q];
      out_last_q <= is_last;
    end
  end

endmodule

FILE: design/utf8_stream_sanitizer.sv
// Top level of the UTF-8 stream sanitizer: front end, job queue, serializer.
// Depends on uss_pkg, uss_front, uss_job_fifo, uss_back, assert_macros.svh.
//
// channel  | direction | payload
// s_axis   | in        | tdata = data_byte, tuser = mode
// m_axis   | out       | tdata = out_byte, tlast = last_of_run
//
// An item is taken every cycle while the four-entry job queue has room.
// Output runs at one byte per cycle while m_axis_tready accepts; an item giving n bytes holds the serializer
// until all n are sent. The first byte passes the job queue, then the output register.
// Reset clears the sequence state, queue and output valid flag at once.
// Output stalls back up into the queue, then into s_axis_tready.
`include "assert_macros.svh"

module utf8_stream_sanitizer import uss_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tuser,   // [0] mode
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast
);

  logic        job_valid;
  job_t        job;
  logic        fifo_full;
  logic        pop;
  logic        head_valid;
  job_t        head;
  front_stat_t stat;
  logic        held_ok;

  uss_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .mode_i      (s_axis_tuser),
    .byte_i      (s_axis_tdata),
    .job_ready_i (!fifo_full),
    .job_valid_o (job_valid),
    .job_o       (job),
    .stat_o      (stat)
  );

  uss_job_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (job_valid),
    .push_job_i   (job),
    .full_o       (fifo_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  uss_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

  assign held_ok = (stat.expected_length > 3'(stat.held_count)) &&
                   (stat.expected_length <= 3'd4);

  `USS_NEVER(a_no_push_when_full, clk_i, rst_ni, job_valid && fifo_full)
  `USS_ASSERT(a_held_within_len, clk_i, rst_ni, (stat.held_count != 2'd0) |-> held_ok)
  `USS_ASSERT(a_run_continues, clk_i, rst_ni, (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)

endmodule

FILE: verif/tb_utf8_stream_sanitizer.sv
// Self-checking testbench for utf8_stream_sanitizer: directed table, then random UTF-8 traffic.
// Predicts output bytes per item and scores them in order; depends on uss_pkg and the RTL only.
`timescale 1ns / 100ps

module tb_utf8_stream_sanitizer;
  import uss_pkg::*;

  localparam logic       ModeData   = 1'b0;
  localparam logic       ModeDrop   = 1'b1;
  localparam logic [3:0] NoFix      = 4'hF;
  localparam int         HoldCycles = 80;
  localparam int         ReportMax  = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  typedef struct packed {
    logic        mode;
    logic [7:0]  data;
    logic [3:0]  nfix;
    logic [47:0] fix;   // first byte in [47:40]
  } dir_row_t;

  localparam dir_row_t DirRows [26] = '{
    '{ModeData, 8'h00, 4'd1, 48'h000000000000},
    '{ModeData, 8'h7F, 4'd1, 48'h7F0000000000},
    '{ModeData, 8'h80, 4'd3, 48'hEFBFBD000000},
    '{ModeData, 8'hFF, 4'd3, 48'hEFBFBD000000},
    '{ModeData, 8'hC1, 4'd3, 48'hEFBFBD000000},
    '{ModeData, 8'hF5, 4'd3, 48'hEFBFBD000000},
    '{ModeData, 8'hC2, 4'd0, 48'h000000000000},
    '{ModeData, 8'h80, NoFix, 48'h0},
    '{ModeData, 8'hE0, NoFix, 48'h0},
    '{ModeData, 8'h9F, 4'd6, 48'hEFBFBDEFBFBD},
    '{ModeData, 8'hED, NoFix, 48'h0},
    '{ModeData, 8'hA0, 4'd6, 48'hEFBFBDEFBFBD},
    '{ModeData, 8'hF0, NoFix, 48'h0},
    '{ModeData, 8'h90, NoFix, 48'h0},
    '{ModeData, 8'h80, NoFix, 48'h0},
    '{ModeData, 8'h80, NoFix, 48'h0},
    '{ModeData, 8'hF4, NoFix, 48'h0},
    '{ModeData, 8'h8F, NoFix, 48'h0},
    '{ModeData, 8'hBF, NoFix, 48'h0},
    '{ModeData, 8'hBF, NoFix, 48'h0},
    '{ModeData, 8'hE1, NoFix, 48'h0},
    '{ModeData, 8'h80, NoFix, 48'h0},
    '{ModeDrop, 8'hFF, 4'd0, 48'h000000000000},
    '{ModeData, 8'h41, NoFix, 48'h0},
    '{ModeData, 8'hC2, NoFix, 48'h0},
    '{ModeData, 8'h41, NoFix, 48'h0}
  };

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;    // [7:0] data_byte
  logic       s_axis_tuser;    // [0] mode
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;    // [7:0] out_byte
  logic       m_axis_tlast;

  logic [1:0] held_n;
  logic [2:0] seq_len_r;
  logic [7:0] lo_bnd;
  logic [7:0] hi_bnd;
  logic [7:0] held_buf [3];

  out_beat_t  step_beats [$];
  out_beat_t  expected_beats [$];
  int         bad_beats    = 0;
  int         items_sent   = 0;
  int         tx_idle_pct  = 0;
  int         rx_stall_pct = 0;
  logic       long_hold_req = 1'b0;
  int         hold_ctr     = 0;
  bit         hold_done    = 1'b0;

  utf8_stream_sanitizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic push_beat(input logic [7:0] b);
    step_beats.push_back('{data: b, last: 1'b0});
  endtask

  task automatic push_repl();
    push_beat(Repl0);
    push_beat(Repl1);
    push_beat(Repl2);
  endtask

  task automatic open_seq(input logic [7:0] b);
    if (b < AsciiLimit) begin
      push_beat(b);
    end else if (b < Lead2Min || b >= LeadLimit) begin
      push_repl();
    end else begin
      held_buf[0] = b;
      held_n      = 2'd1;
      seq_len_r   = (b < Lead3Min) ? 3'd2 : (b < Lead4Min) ? 3'd3 : 3'd4;
      lo_bnd      = ContLow;
      hi_bnd      = ContHigh;
      case (b)
        LeadE0:  lo_bnd = LowAfterE0;
        LeadED:  hi_bnd = HighAfterED;
        LeadF0:  lo_bnd = LowAfterF0;
        LeadF4:  hi_bnd = HighAfterF4;
        default: ;
      endcase
    end
  endtask

  task automatic sanitize_byte(input logic mode, input logic [7:0] b);
    out_beat_t tail;
    step_beats.delete();
    if (mode == ModeDrop) begin
      held_n    = 2'd0;
      seq_len_r = 3'd0;
    end else if (held_n == 2'd0) begin
      open_seq(b);
    end else if (b < lo_bnd || b > hi_bnd) begin
      held_n = 2'd0;
      push_repl();
      open_seq(b);
    end else begin
      lo_bnd = ContLow;
      hi_bnd = ContHigh;
      if (int'(held_n) + 1 >= int'(seq_len_r) || held_n == 2'd3) begin
        for (int i = 0; i < int'(held_n); i++) push_beat(held_buf[i]);
        push_beat(b);
        held_n = 2'd0;
      end else begin
        held_buf[held_n] = b;
        held_n = held_n + 2'd1;
      end
    end
    if (step_beats.size() > 0) begin
      tail = step_beats.pop_back();
      tail.last = 1'b1;
      step_beats.push_back(tail);
    end
  endtask

  task automatic send_item(input logic mode, input logic [7:0] b, input logic [3:0] nfix,
                           input logic [47:0] fix);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
    sanitize_byte(mode, b);
    if (nfix == NoFix) begin
      foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
    end else begin
      for (int k = 0; k < int'(nfix); k++)
        expected_beats.push_back('{data: fix[47-8*k -: 8], last: (k == int'(nfix) - 1)});
    end
  endtask

  // keep = number of leading bytes of the well-formed sequence to send
  task automatic send_seq(input int len, input int keep);
    logic [7:0] seq [4];
    case (len)
      1:       seq[0] = 8'($urandom_range(0, AsciiLimit - 1));
      2:       seq[0] = 8'($urandom_range(Lead2Min, Lead3Min - 1));
      3:       seq[0] = 8'($urandom_range(Lead3Min, Lead4Min - 1));
      default: seq[0] = 8'($urandom_range(Lead4Min, LeadLimit - 1));
    endcase
    for (int k = 1; k < 4; k++) seq[k] = 8'($urandom_range(ContLow, ContHigh));
    case (seq[0])
      LeadE0:  seq[1] = 8'($urandom_range(LowAfterE0, ContHigh));
      LeadED:  seq[1] = 8'($urandom_range(ContLow, HighAfterED));
      LeadF0:  seq[1] = 8'($urandom_range(LowAfterF0, ContHigh));
      LeadF4:  seq[1] = 8'($urandom_range(ContLow, HighAfterF4));
      default: ;
    endcase
    for (int k = 0; k < keep; k++) send_item(ModeData, seq[k], NoFix, '0);
  endtask

  task automatic send_random(input int goal);
    int pick;
    int len;
    while (items_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        len = $urandom_range(1, 4);
        send_seq(len, len);
      end else if (pick < 70) begin
        len = $urandom_range(2, 4);
        send_seq(len, $urandom_range(1, len - 1));
      end else if (pick < 78) begin
        send_item(ModeDrop, 8'($urandom_range(255)), NoFix, '0);
      end else begin
        send_item(ModeData, 8'($urandom_range(255)), NoFix, '0);
      end
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_beats.size() == 0) begin
          if (bad_beats < ReportMax)
            $display("unexpected byte %h last %b", m_axis_tdata, m_axis_tlast);
          bad_beats++;
        end else begin
          out_beat_t want;
          want = expected_beats.pop_front();
          if (want.data !== m_axis_tdata || want.last !== m_axis_tlast) begin
            if (bad_beats < ReportMax)
              $display("byte mismatch: expected %h last %b, got %h last %b",
                       want.data, want.last, m_axis_tdata, m_axis_tlast);
            bad_beats++;
          end
        end
      end
      if (long_hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        hold_ctr++;
        if (hold_ctr >= HoldCycles) hold_done = 1'b1;
      end else begin
        if (!long_hold_req) begin
          hold_done = 1'b0;
          hold_ctr  = 0;
        end
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tuser  = ModeData;
    held_n        = 2'd0;
    seq_len_r     = 3'd0;
    lo_bnd        = ContLow;
    hi_bnd        = ContHigh;
    foreach (held_buf[i]) held_buf[i] = 8'h00;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirRows[i])
      send_item(DirRows[i].mode, DirRows[i].data, DirRows[i].nfix, DirRows[i].fix);
    wait_drained();

    send_random(items_sent + 28);
    wait_drained();

    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    long_hold_req <= 1'b1;
    send_random(items_sent + 28);
    wait_drained();
    long_hold_req <= 1'b0;

    tx_idle_pct = 45;
    send_random(items_sent + 28);
    wait_drained();

    tx_idle_pct  = 0;
    rx_stall_pct = 45;
    send_random(items_sent + 28);
    wait_drained();

    tx_idle_pct  = 38;
    rx_stall_pct = 38;
    send_random(items_sent + 28);
    wait_drained();

    repeat (20) @(posedge clk_i);
    if (bad_beats == 0 && expected_beats.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
